### rtl/sdepid_pkg.sv
// ----------------------------------------------------------------------------
// sdepid_pkg
// Shared types and constants for the straight drive encoder pid block.
// ----------------------------------------------------------------------------
package sdepid_pkg;

  // integral clamp and wheel command clamp
  localparam int unsigned SUM_LIMIT = 1000;
  localparam int unsigned CMD_LIMIT = 255;

  // register reset values
  localparam logic [7:0]  BASE_RESET   = 8'd150;
  localparam logic [15:0] GAIN_P_RESET = 16'd1280;
  localparam logic [15:0] GAIN_I_RESET = 16'd26;
  localparam logic [15:0] GAIN_D_RESET = 16'd512;

  // register map, word index
  typedef enum logic [2:0] {
    REG_TARGET  = 3'd0,
    REG_REVERSE = 3'd1,
    REG_BASE    = 3'd2,
    REG_GAIN_P  = 3'd3,
    REG_GAIN_I  = 3'd4,
    REG_GAIN_D  = 3'd5
  } sdepid_reg_e;

  // input item kind
  typedef enum logic {
    KIND_START  = 1'b0,
    KIND_SAMPLE = 1'b1
  } sdepid_kind_e;

  // configuration register set
  typedef struct packed {
    logic [23:0] target_ticks;
    logic        reverse;
    logic [7:0]  base_power;
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
  } sdepid_cfg_t;

  // per-item control flags carried down the pipeline
  typedef struct packed {
    logic zero;  // force all duties to zero
    logic done;  // both wheels at target
  } sdepid_flags_t;

endpackage

### rtl/sdepid_regs.sv
// ----------------------------------------------------------------------------
// sdepid_regs
// APB-style configuration registers: target, direction, base power, gains.
// ----------------------------------------------------------------------------
module sdepid_regs (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [4:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output sdepid_pkg::sdepid_cfg_t cfg_o
);

  sdepid_pkg::sdepid_cfg_t cfg_q, cfg_d;
  sdepid_pkg::sdepid_reg_e reg_sel;
  logic                    wr_en;

  assign pready  = 1'b1;
  assign reg_sel = sdepid_pkg::sdepid_reg_e'(paddr[4:2]);
  assign wr_en   = psel & penable & pwrite;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        sdepid_pkg::REG_TARGET:  cfg_d.target_ticks = pwdata[23:0];
        sdepid_pkg::REG_REVERSE: cfg_d.reverse      = pwdata[0];
        sdepid_pkg::REG_BASE:    cfg_d.base_power   = pwdata[7:0];
        sdepid_pkg::REG_GAIN_P:  cfg_d.gain_p       = pwdata[15:0];
        sdepid_pkg::REG_GAIN_I:  cfg_d.gain_i       = pwdata[15:0];
        sdepid_pkg::REG_GAIN_D:  cfg_d.gain_d       = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_ticks <= '0;
      cfg_q.reverse      <= 1'b0;
      cfg_q.base_power   <= sdepid_pkg::BASE_RESET;
      cfg_q.gain_p       <= sdepid_pkg::GAIN_P_RESET;
      cfg_q.gain_i       <= sdepid_pkg::GAIN_I_RESET;
      cfg_q.gain_d       <= sdepid_pkg::GAIN_D_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // register read mux
  always_comb begin
    case (reg_sel)
      sdepid_pkg::REG_TARGET:  prdata = {8'd0, cfg_q.target_ticks};
      sdepid_pkg::REG_REVERSE: prdata = {31'd0, cfg_q.reverse};
      sdepid_pkg::REG_BASE:    prdata = {24'd0, cfg_q.base_power};
      sdepid_pkg::REG_GAIN_P:  prdata = {16'd0, cfg_q.gain_p};
      sdepid_pkg::REG_GAIN_I:  prdata = {16'd0, cfg_q.gain_i};
      sdepid_pkg::REG_GAIN_D:  prdata = {16'd0, cfg_q.gain_d};
      default:                 prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/sdepid_err.sv
// ----------------------------------------------------------------------------
// sdepid_err
// Input register, error and integral state update, and the three gain
// products, registered for the command stage.
// ----------------------------------------------------------------------------
module sdepid_err #(
  parameter int unsigned COUNT_WIDTH = 25,
  localparam int unsigned ErrW  = COUNT_WIDTH + 1,
  localparam int unsigned PW    = COUNT_WIDTH + 18,
  localparam int unsigned DW    = COUNT_WIDTH + 19,
  localparam int unsigned IW    = 28
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sdepid_pkg::sdepid_cfg_t       cfg_i,
  // input item side
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic                          kind_i,
  input  logic signed [COUNT_WIDTH-1:0] left_i,
  input  logic signed [COUNT_WIDTH-1:0] right_i,
  // product side
  output logic                          valid_o,
  input  logic                          ready_i,
  output sdepid_pkg::sdepid_flags_t     flags_o,
  output logic signed [PW-1:0]          p_prod_o,
  output logic signed [IW-1:0]          i_prod_o,
  output logic signed [DW-1:0]          d_prod_o
);

  localparam int unsigned CmpW = ((COUNT_WIDTH > 24) ? COUNT_WIDTH : 24) + 1;
  localparam int unsigned SumW = ((COUNT_WIDTH + 2) > 12) ? (COUNT_WIDTH + 2) : 12;

  // input register
  logic                          in_valid_q, in_valid_d;
  logic                          kind_q;
  logic signed [COUNT_WIDTH-1:0] left_q, right_q;

  // state
  logic signed [10:0]            error_sum_q, error_sum_d;
  logic signed [ErrW-1:0]        last_error_q, last_error_d;

  // product register
  logic                          prod_valid_q, prod_valid_d;
  sdepid_pkg::sdepid_flags_t     flags_q, flags_d;
  logic signed [PW-1:0]          p_prod_q, p_prod_d;
  logic signed [IW-1:0]          i_prod_q, i_prod_d;
  logic signed [DW-1:0]          d_prod_q, d_prod_d;

  logic                          in_acc, in_move, prod_ready;
  logic                          is_start, reached;
  logic [COUNT_WIDTH-1:0]        abs_l, abs_r;
  logic signed [ErrW-1:0]        err;
  logic signed [ErrW:0]          diff;
  logic signed [SumW-1:0]        sum_raw, lim_hi, lim_lo;
  logic signed [10:0]            sum_sat;

  // handshake
  assign prod_ready = !prod_valid_q || ready_i;
  assign in_move    = in_valid_q && prod_ready;
  assign ready_o    = !in_valid_q || prod_ready;
  assign in_acc     = valid_i && ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_acc) begin
      in_valid_d = 1'b1;
    end else if (in_move) begin
      in_valid_d = 1'b0;
    end
    prod_valid_d = prod_ready ? in_valid_q : prod_valid_q;
  end

  // target check on both wheel magnitudes
  always_comb begin
    is_start = (sdepid_pkg::sdepid_kind_e'(kind_q) == sdepid_pkg::KIND_START);
    abs_l    = left_q[COUNT_WIDTH-1]  ? (~left_q + 1'b1)  : left_q;
    abs_r    = right_q[COUNT_WIDTH-1] ? (~right_q + 1'b1) : right_q;
    reached  = (CmpW'(abs_l) >= CmpW'(cfg_i.target_ticks)) &&
               (CmpW'(abs_r) >= CmpW'(cfg_i.target_ticks));
  end

  // error, derivative difference and saturated integral
  always_comb begin
    err     = ErrW'(left_q) - ErrW'(right_q);
    diff    = (ErrW + 1)'(err) - (ErrW + 1)'(last_error_q);
    lim_hi  = SumW'(sdepid_pkg::SUM_LIMIT);
    lim_lo  = -lim_hi;
    sum_raw = SumW'(error_sum_q) + SumW'(err);
    if (sum_raw > lim_hi) begin
      sum_sat = 11'(lim_hi);
    end else if (sum_raw < lim_lo) begin
      sum_sat = 11'(lim_lo);
    end else begin
      sum_sat = sum_raw[10:0];
    end
  end

  // state update, one item per cycle unless the product register is stalled
  always_comb begin
    error_sum_d  = error_sum_q;
    last_error_d = last_error_q;
    if (in_move) begin
      if (is_start) begin
        error_sum_d  = '0;
        last_error_d = '0;
      end else if (!reached) begin
        error_sum_d  = sum_sat;
        last_error_d = err;
      end
    end
  end

  // gain products
  always_comb begin
    flags_d.zero = is_start || reached;
    flags_d.done = !is_start && reached;
    p_prod_d     = PW'(err) * PW'($signed({1'b0, cfg_i.gain_p}));
    i_prod_d     = IW'(sum_sat) * IW'($signed({1'b0, cfg_i.gain_i}));
    d_prod_d     = DW'(diff) * DW'($signed({1'b0, cfg_i.gain_d}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      prod_valid_q <= 1'b0;
      error_sum_q  <= '0;
      last_error_q <= '0;
    end else begin
      in_valid_q   <= in_valid_d;
      prod_valid_q <= prod_valid_d;
      error_sum_q  <= error_sum_d;
      last_error_q <= last_error_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q  <= kind_i;
      left_q  <= left_i;
      right_q <= right_i;
    end
    if (in_move) begin
      flags_q  <= flags_d;
      p_prod_q <= p_prod_d;
      i_prod_q <= i_prod_d;
      d_prod_q <= d_prod_d;
    end
  end

  assign valid_o  = prod_valid_q;
  assign flags_o  = flags_q;
  assign p_prod_o = p_prod_q;
  assign i_prod_o = i_prod_q;
  assign d_prod_o = d_prod_q;

  // integral never leaves its clamp range
  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (error_sum_q <= 11'sd1000) && (error_sum_q >= -11'sd1000))
    else $error("integral out of range");

  // a start item leaves cleared state behind
  a_start_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_move && is_start) |=> (error_sum_q == '0) && (last_error_q == '0))
    else $error("state not cleared by start item");

endmodule

### rtl/sdepid_mix.sv
// ----------------------------------------------------------------------------
// sdepid_mix
// Truncates the gain products, forms both wheel commands, saturates them
// and maps them to bridge channel duties in the result register.
// ----------------------------------------------------------------------------
module sdepid_mix #(
  parameter int unsigned COUNT_WIDTH = 25,
  localparam int unsigned PW = COUNT_WIDTH + 18,
  localparam int unsigned DW = COUNT_WIDTH + 19,
  localparam int unsigned IW = 28
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sdepid_pkg::sdepid_cfg_t   cfg_i,
  // product side
  input  logic                      valid_i,
  output logic                      ready_o,
  input  sdepid_pkg::sdepid_flags_t flags_i,
  input  logic signed [PW-1:0]      p_prod_i,
  input  logic signed [IW-1:0]      i_prod_i,
  input  logic signed [DW-1:0]      d_prod_i,
  // result side
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [7:0]                left_a_duty_o,
  output logic [7:0]                left_b_duty_o,
  output logic [7:0]                right_a_duty_o,
  output logic [7:0]                right_b_duty_o,
  output logic                      done_res_o
);

  localparam int unsigned CorrW = COUNT_WIDTH + 13;
  localparam int unsigned CmdW  = COUNT_WIDTH + 14;

  logic                   out_valid_q, out_valid_d;
  logic [7:0]             la_q, lb_q, ra_q, rb_q;
  logic [7:0]             la_d, lb_d, ra_d, rb_d;
  logic                   done_q;
  logic                   load;

  logic signed [PW-1:0]   p_adj;
  logic signed [IW-1:0]   i_adj;
  logic signed [DW-1:0]   d_adj;
  logic signed [PW-9:0]   p_q88;
  logic signed [IW-9:0]   i_q88;
  logic signed [DW-9:0]   d_q88;
  logic signed [CorrW-1:0] corr;
  logic signed [8:0]      base9;
  logic signed [CmdW-1:0] l_raw, r_raw, cmd_hi, cmd_lo;
  logic signed [8:0]      l_sat, r_sat, l_cmd, r_cmd, l_mag, r_mag;

  // handshake
  assign ready_o = !out_valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign out_valid_d = ready_o ? valid_i : out_valid_q;

  // divide by 256, truncated toward zero
  always_comb begin
    p_adj = p_prod_i + PW'({8{p_prod_i[PW-1]}});
    i_adj = i_prod_i + IW'({8{i_prod_i[IW-1]}});
    d_adj = d_prod_i + DW'({8{d_prod_i[DW-1]}});
    p_q88 = p_adj[PW-1:8];
    i_q88 = i_adj[IW-1:8];
    d_q88 = d_adj[DW-1:8];
    corr  = CorrW'(p_q88) + CorrW'(i_q88) + CorrW'(d_q88);
  end

  // forward commands, saturated; reverse flips both signs
  always_comb begin
    base9  = $signed({1'b0, cfg_i.base_power});
    cmd_hi = CmdW'(sdepid_pkg::CMD_LIMIT);
    cmd_lo = -cmd_hi;
    l_raw  = CmdW'(base9) - CmdW'(corr);
    r_raw  = CmdW'(base9) + CmdW'(corr);
    if (l_raw > cmd_hi) begin
      l_sat = 9'(cmd_hi);
    end else if (l_raw < cmd_lo) begin
      l_sat = 9'(cmd_lo);
    end else begin
      l_sat = l_raw[8:0];
    end
    if (r_raw > cmd_hi) begin
      r_sat = 9'(cmd_hi);
    end else if (r_raw < cmd_lo) begin
      r_sat = 9'(cmd_lo);
    end else begin
      r_sat = r_raw[8:0];
    end
    l_cmd = cfg_i.reverse ? -l_sat : l_sat;
    r_cmd = cfg_i.reverse ? -r_sat : r_sat;
    l_mag = -l_cmd;
    r_mag = -r_cmd;
  end

  // bridge channel mapping
  always_comb begin
    la_d = '0;
    lb_d = '0;
    ra_d = '0;
    rb_d = '0;
    if (!flags_i.zero) begin
      if (l_cmd > 9'sd0) begin
        la_d = l_cmd[7:0];
      end else if (l_cmd < 9'sd0) begin
        lb_d = l_mag[7:0];
      end
      if (r_cmd > 9'sd0) begin
        rb_d = r_cmd[7:0];
      end else if (r_cmd < 9'sd0) begin
        ra_d = r_mag[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (load) begin
      la_q   <= la_d;
      lb_q   <= lb_d;
      ra_q   <= ra_d;
      rb_q   <= rb_d;
      done_q <= flags_i.done;
    end
  end

  assign valid_o        = out_valid_q;
  assign left_a_duty_o  = la_q;
  assign left_b_duty_o  = lb_q;
  assign right_a_duty_o = ra_q;
  assign right_b_duty_o = rb_q;
  assign done_res_o     = done_q;

  // a wheel never drives both bridge channels
  a_one_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((la_q == '0) || (lb_q == '0)) && ((ra_q == '0) || (rb_q == '0)))
    else $error("both bridge channels driven");

  // a finished move drives nothing
  a_done_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && done_q) |-> (la_q == '0) && (lb_q == '0) && (ra_q == '0) && (rb_q == '0))
    else $error("duty nonzero with done set");

endmodule

### rtl/straight_drive_encoder_pid.sv
// ----------------------------------------------------------------------------
// straight_drive_encoder_pid
// Straight-line PID drive controller for a two-wheel robot with encoders.
// ----------------------------------------------------------------------------
// Takes one item per clock unless the result side stalls, and returns one
// result per item, in order. The input register, the gain product register
// and the result register form a three-register pipeline, and the integral
// and previous error update as an item moves from the input register into
// the gain product register, so items may follow back to back.
// Input tdata holds left_count then right_count, each COUNT_WIDTH bits two's
// complement; tuser is the kind (0 start of move, 1 encoder sample). Output
// tdata holds left_a, left_b, right_a, right_b duties; tuser is done.
// Registers sit at byte addresses 0, 4, ... 20: target_ticks, reverse,
// base_power, gain_p, gain_i, gain_d (gains unsigned Q8.8).
module straight_drive_encoder_pid #(
  parameter int unsigned COUNT_WIDTH = 25
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [4:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready,
  // input items
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // left_count, right_count, zero pad
  input  logic [((2*COUNT_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  // kind
  input  logic                                   s_axis_tuser,
  // result items
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // left_a_duty, left_b_duty, right_a_duty, right_b_duty
  output logic [31:0]                            m_axis_tdata,
  // done_res
  output logic                                   m_axis_tuser
);

  localparam int unsigned PW = COUNT_WIDTH + 18;
  localparam int unsigned DW = COUNT_WIDTH + 19;
  localparam int unsigned IW = 28;

  sdepid_pkg::sdepid_cfg_t   cfg;
  sdepid_pkg::sdepid_flags_t flags;
  logic                      prod_valid, prod_ready;
  logic signed [PW-1:0]      p_prod;
  logic signed [IW-1:0]      i_prod;
  logic signed [DW-1:0]      d_prod;
  logic [7:0]                la, lb, ra, rb;

  // configuration registers
  sdepid_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // error, integral and gain products
  sdepid_err #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_err (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .kind_i   (s_axis_tuser),
    .left_i   ($signed(s_axis_tdata[COUNT_WIDTH-1:0])),
    .right_i  ($signed(s_axis_tdata[2*COUNT_WIDTH-1:COUNT_WIDTH])),
    .valid_o  (prod_valid),
    .ready_i  (prod_ready),
    .flags_o  (flags),
    .p_prod_o (p_prod),
    .i_prod_o (i_prod),
    .d_prod_o (d_prod)
  );

  // commands and duties
  sdepid_mix #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_mix (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .valid_i        (prod_valid),
    .ready_o        (prod_ready),
    .flags_i        (flags),
    .p_prod_i       (p_prod),
    .i_prod_i       (i_prod),
    .d_prod_i       (d_prod),
    .valid_o        (m_axis_tvalid),
    .ready_i        (m_axis_tready),
    .left_a_duty_o  (la),
    .left_b_duty_o  (lb),
    .right_a_duty_o (ra),
    .right_b_duty_o (rb),
    .done_res_o     (m_axis_tuser)
  );

  assign m_axis_tdata = {rb, ra, lb, la};

endmodule

### test/straight_drive_encoder_pid_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// straight_drive_encoder_pid_tb
// Self-checking bench for the straight drive pid controller. Start and sample
// items go in on the input stream and registers are set over the config port.
// A tracker class mirrors the integral, the previous error and the register
// set, predicts the four bridge duties and the done flag of every item, and
// checks each result in order against them.
// ----------------------------------------------------------------------------
module straight_drive_encoder_pid_tb;

  localparam int CW             = 25;
  localparam int TDW            = ((2*CW+7)/8)*8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam longint COUNT_MAX  = (64'sd1 <<< (CW-1)) - 1;

  // spare register indexes past the map, writes there are dropped
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [7:0] left_a;
    logic [7:0] left_b;
    logic [7:0] right_a;
    logic [7:0] right_b;
    logic       done;
  } duty_res_t;

  // mirrors controller state and checks bridge duties in order
  class wheel_duty_tracker;
    sdepid_pkg::sdepid_cfg_t cfg;
    longint      error_sum;
    longint      last_error;
    duty_res_t   expected_duties[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      cfg.target_ticks = '0;
      cfg.reverse      = 1'b0;
      cfg.base_power   = sdepid_pkg::BASE_RESET;
      cfg.gain_p       = sdepid_pkg::GAIN_P_RESET;
      cfg.gain_i       = sdepid_pkg::GAIN_I_RESET;
      cfg.gain_d       = sdepid_pkg::GAIN_D_RESET;
      error_sum  = 0;
      last_error = 0;
      mismatches = 0;
      checked    = 0;
    endfunction

    static function longint clamp_range(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // q8.8 gain product, quotient truncated toward zero
    static function longint q88_scale(longint x, longint gain);
      return (x * gain) / 256;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        sdepid_pkg::REG_TARGET:  cfg.target_ticks = value[23:0];
        sdepid_pkg::REG_REVERSE: cfg.reverse      = value[0];
        sdepid_pkg::REG_BASE:    cfg.base_power   = value[7:0];
        sdepid_pkg::REG_GAIN_P:  cfg.gain_p       = value[15:0];
        sdepid_pkg::REG_GAIN_I:  cfg.gain_i       = value[15:0];
        sdepid_pkg::REG_GAIN_D:  cfg.gain_d       = value[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_duties.size();
    endfunction

    function void note_item(sdepid_pkg::sdepid_kind_e kind, logic [CW-1:0] left_raw,
                            logic [CW-1:0] right_raw);
      duty_res_t res;
      longint    l, r, l_mag, r_mag, err, corr, sens, base, lcmd, rcmd, lim;
      res = '0;
      // start of move clears the loop state
      if (kind == sdepid_pkg::KIND_START) begin
        error_sum  = 0;
        last_error = 0;
        expected_duties.push_back(res);
        return;
      end
      l = $signed(left_raw);
      r = $signed(right_raw);
      l_mag = (l < 0) ? -l : l;
      r_mag = (r < 0) ? -r : r;
      // both wheels at target, motors off and state kept
      if (l_mag >= longint'(cfg.target_ticks) && r_mag >= longint'(cfg.target_ticks)) begin
        res.done = 1'b1;
        expected_duties.push_back(res);
        return;
      end
      err       = l - r;
      lim       = longint'(sdepid_pkg::SUM_LIMIT);
      error_sum = clamp_range(error_sum + err, -lim, lim);
      corr      = q88_scale(err, cfg.gain_p) + q88_scale(error_sum, cfg.gain_i)
                + q88_scale(err - last_error, cfg.gain_d);
      last_error = err;
      sens = cfg.reverse ? -1 : 1;
      base = sens * longint'(cfg.base_power);
      lim  = longint'(sdepid_pkg::CMD_LIMIT);
      lcmd = clamp_range(base - sens * corr, -lim, lim);
      rcmd = clamp_range(base + sens * corr, -lim, lim);
      // map signed wheel commands onto bridge channels
      if (lcmd > 0) res.left_a = 8'(lcmd);
      else if (lcmd < 0) res.left_b = 8'(-lcmd);
      if (rcmd > 0) res.right_b = 8'(rcmd);
      else if (rcmd < 0) res.right_a = 8'(-rcmd);
      expected_duties.push_back(res);
    endfunction

    function void check_duties(logic [31:0] data, logic done_bit);
      duty_res_t got, want;
      got.left_a  = data[7:0];
      got.left_b  = data[15:8];
      got.right_a = data[23:16];
      got.right_b = data[31:24];
      got.done    = done_bit;
      if (expected_duties.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing expected: la=%0d lb=%0d ra=%0d rb=%0d done=%0b",
                   got.left_a, got.left_b, got.right_a, got.right_b, got.done);
        return;
      end
      want = expected_duties.pop_front();
      if (got.left_a !== want.left_a || got.left_b !== want.left_b ||
          got.right_a !== want.right_a || got.right_b !== want.right_b ||
          got.done !== want.done) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: exp %0d %0d %0d %0d done=%0b, got %0d %0d %0d %0d done=%0b",
                   checked, want.left_a, want.left_b, want.right_a, want.right_b,
                   want.done, got.left_a, got.left_b, got.right_a, got.right_b, got.done);
      end
      checked++;
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           psel;
  logic           penable;
  logic           pwrite;
  logic [4:0]     paddr;
  logic [31:0]    pwdata;
  logic [31:0]    prdata;
  logic           pready;
  logic           s_axis_tvalid;
  logic           s_axis_tready;
  logic [TDW-1:0] s_axis_tdata;   // left_count, right_count, zero pad
  logic           s_axis_tuser;   // kind
  logic           m_axis_tvalid;
  logic           m_axis_tready;
  logic [31:0]    m_axis_tdata;   // left_a, left_b, right_a, right_b duties
  logic           m_axis_tuser;   // done_res

  wheel_duty_tracker sb;
  int unsigned       src_idle;
  int unsigned       sink_idle;
  int unsigned       items_sent;
  int unsigned       stall_cycles;

  straight_drive_encoder_pid #(
    .COUNT_WIDTH(CW)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // result side back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle);
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_item(sdepid_pkg::sdepid_kind_e'(s_axis_tuser), s_axis_tdata[CW-1:0],
                     s_axis_tdata[2*CW-1:CW]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_duties(m_axis_tdata, m_axis_tuser);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (!s_axis_tvalid && sb.pending() == 0)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // register write, setup then access, unused bits filled with noise
  task automatic cfg_write(logic [2:0] idx, logic [31:0] field);
    logic [31:0] mask, value;
    case (idx)
      sdepid_pkg::REG_TARGET:  mask = 32'h00FF_FFFF;
      sdepid_pkg::REG_REVERSE: mask = 32'h0000_0001;
      sdepid_pkg::REG_BASE:    mask = 32'h0000_00FF;
      sdepid_pkg::REG_GAIN_P,
      sdepid_pkg::REG_GAIN_I,
      sdepid_pkg::REG_GAIN_D:  mask = 32'h0000_FFFF;
      default:                 mask = 32'h0000_0000;
    endcase
    value = (field & mask) | ($urandom & ~mask);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_reg(idx, value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apply_cfg(sdepid_pkg::sdepid_cfg_t c);
    cfg_write(sdepid_pkg::REG_TARGET,  32'(c.target_ticks));
    cfg_write(sdepid_pkg::REG_REVERSE, 32'(c.reverse));
    cfg_write(sdepid_pkg::REG_BASE,    32'(c.base_power));
    cfg_write(sdepid_pkg::REG_GAIN_P,  32'(c.gain_p));
    cfg_write(sdepid_pkg::REG_GAIN_I,  32'(c.gain_i));
    cfg_write(sdepid_pkg::REG_GAIN_D,  32'(c.gain_d));
  endtask

  // stop sending and wait for every expected result
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic send_item(sdepid_pkg::sdepid_kind_e kind, logic [CW-1:0] left,
                           logic [CW-1:0] right);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = kind;
    s_axis_tdata  = {{(TDW-2*CW){1'b0}}, right, left};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_counts(longint left, longint right);
    send_item(sdepid_pkg::KIND_SAMPLE, CW'(left), CW'(right));
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 4))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(0, 2048));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sdepid_pkg::sdepid_cfg_t pick_cfg();
    sdepid_pkg::sdepid_cfg_t c;
    case ($urandom_range(0, 7))
      0:       c.target_ticks = 24'd0;
      1:       c.target_ticks = 24'hFF_FFFF;
      default: c.target_ticks = 24'($urandom_range(20, 3000));
    endcase
    c.reverse = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0:       c.base_power = 8'd0;
      1:       c.base_power = 8'd255;
      default: c.base_power = 8'($urandom);
    endcase
    c.gain_p = pick_gain();
    c.gain_i = pick_gain();
    c.gain_d = pick_gain();
    return c;
  endfunction

  // one move: start item, then counts climbing toward and past the target
  task automatic run_move(int unsigned quota);
    longint      l, r;
    int unsigned stepmax, steps;
    stepmax = (sb.cfg.target_ticks == 0) ? 64 : sb.cfg.target_ticks / 12 + 1;
    steps   = $urandom_range(4, 40);
    send_item(sdepid_pkg::KIND_START, CW'($urandom), CW'($urandom));
    l = 0;
    r = 0;
    for (int unsigned k = 0; k < steps && items_sent < quota; k++) begin
      l += $urandom_range(0, stepmax);
      r += $urandom_range(0, stepmax);
      // mostly the right wheel tracks the left one closely
      if ($urandom_range(0, 3) != 0) r = l + longint'($urandom_range(0, 40)) - 20;
      l = wheel_duty_tracker::clamp_range(l, -COUNT_MAX, COUNT_MAX);
      r = wheel_duty_tracker::clamp_range(r, -COUNT_MAX, COUNT_MAX);
      if (sb.cfg.reverse) send_counts(-l, -r);
      else send_counts(l, r);
    end
  endtask

  initial begin
    sdepid_pkg::sdepid_cfg_t c;
    int unsigned quota;
    sb            = new();
    src_idle      = 28;
    sink_idle     = 45;
    items_sent    = 0;
    stall_cycles  = 0;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // zero target after reset, every sample reports done
    send_item(sdepid_pkg::KIND_START, CW'($urandom), CW'($urandom));
    send_counts(0, 0);
    send_counts(COUNT_MAX, -COUNT_MAX - 1);
    drain_results();

    // integral saturation both ways and exact target hit
    cfg_write(sdepid_pkg::REG_TARGET, 32'd1000);
    send_item(sdepid_pkg::KIND_START, CW'($urandom), CW'($urandom));
    send_counts(10, 0);
    send_counts(0, 0);
    repeat (3) send_counts(600, 0);
    send_counts(0, 3000);
    send_counts(1000, -1000);
    send_counts(999, -1000);
    drain_results();

    // widest error, reverse drive, largest gains and power
    c.target_ticks = 24'hFF_FFFF;
    c.reverse      = 1'b1;
    c.base_power   = 8'd255;
    c.gain_p       = 16'hFFFF;
    c.gain_i       = 16'hFFFF;
    c.gain_d       = 16'hFFFF;
    apply_cfg(c);
    send_item(sdepid_pkg::KIND_START, CW'($urandom), CW'($urandom));
    send_counts(COUNT_MAX - 1, -COUNT_MAX - 1);
    send_counts(-COUNT_MAX - 1, COUNT_MAX - 1);
    send_counts(-COUNT_MAX - 1, COUNT_MAX);
    send_counts(5, 5);
    drain_results();

    // zero power and zero gains give zero commands on both wheels
    c.reverse    = 1'b0;
    c.base_power = 8'd0;
    c.gain_p     = 16'h0000;
    c.gain_i     = 16'h0000;
    c.gain_d     = 16'h0000;
    apply_cfg(c);
    send_item(sdepid_pkg::KIND_START, CW'($urandom), CW'($urandom));
    send_counts(3, 7);
    send_counts(100, -100);
    drain_results();

    // writes past the register map must be dropped
    cfg_write(REG_SPARE_A, $urandom);
    cfg_write(REG_SPARE_B, $urandom);
    cfg_write(sdepid_pkg::REG_BASE, 32'd255);
    cfg_write(sdepid_pkg::REG_GAIN_P, 32'(sdepid_pkg::GAIN_P_RESET));
    send_item(sdepid_pkg::KIND_START, CW'($urandom), CW'($urandom));
    send_counts(50, -50);

    // random moves and noise under three idling patterns
    for (int mode = 0; mode < 3; mode++) begin
      src_idle  = (mode == 0) ? 28 : (mode == 1) ? 45 : 0;
      sink_idle = (mode == 0) ? 45 : (mode == 1) ? 28 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        drain_results();
        apply_cfg(pick_cfg());
        quota = items_sent + 155;
        while (items_sent < quota) begin
          if ($urandom_range(0, 4) == 0)
            send_item(($urandom_range(0, 4) == 0) ? sdepid_pkg::KIND_START
                                                  : sdepid_pkg::KIND_SAMPLE,
                      CW'($urandom), CW'($urandom));
          else
            run_move(quota);
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/sdepid_pkg.sv
rtl/sdepid_regs.sv
rtl/sdepid_err.sv
rtl/sdepid_mix.sv
rtl/straight_drive_encoder_pid.sv
test/straight_drive_encoder_pid_tb.sv
